[src/dpqm_pkg.sv]
// Package for the dual-axis PID quad mixer: shared types, register codes,
// reset values and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package dpqm_pkg;

  // Configuration register indexes, in port order.
  typedef enum logic [2:0] {
    REG_ROLL_P   = 3'd0,
    REG_ROLL_I   = 3'd1,
    REG_ROLL_D   = 3'd2,
    REG_PITCH_P  = 3'd3,
    REG_PITCH_I  = 3'd4,
    REG_PITCH_D  = 3'd5,
    REG_INT_CAP  = 3'd6,
    REG_MIN_THR  = 3'd7
  } cfg_reg_t;

  localparam logic [15:0] RST_P_GAIN  = 16'd2304;
  localparam logic [15:0] RST_I_GAIN  = 16'd20;
  localparam logic [15:0] RST_D_GAIN  = 16'd26;
  localparam logic [9:0]  RST_INT_CAP = 10'd256;
  localparam logic [10:0] RST_MIN_THR = 11'd40;

  // Near-zero window: 10*t^2 < 256 gives |t| <= 5, a^2 < 7680 gives |a| <= 87.
  localparam logic signed [12:0] TARGET_QUIET_MAX = 13'sd5;
  localparam logic signed [12:0] ANGLE_QUIET_MAX  = 13'sd87;

  // Largest integral magnitude: cap 1023 output units at 9 fraction bits.
  localparam logic signed [19:0] INTEG_BOUND = 20'sd523776;

  typedef struct packed {
    logic [15:0] roll_p;
    logic [15:0] roll_i;
    logic [15:0] roll_d;
    logic [15:0] pitch_p;
    logic [15:0] pitch_i;
    logic [15:0] pitch_d;
    logic [9:0]  int_cap;
    logic [10:0] min_thr;
  } cfg_t;

  typedef enum logic [1:0] {
    INTEG_HOLD  = 2'd0,
    INTEG_CLEAR = 2'd1,
    INTEG_ACCUM = 2'd2
  } integ_op_t;

  // Per-axis products: p_term in Q.12 output units, i_step in Q.9, d_term in Q.8.
  typedef struct packed {
    logic signed [30:0] p_term;
    logic signed [27:0] i_step;
    logic signed [32:0] d_term;
  } axis_terms_t;

  // One classified item handed from front to back.
  typedef struct packed {
    axis_terms_t roll;
    axis_terms_t pitch;
    integ_op_t   op;
    logic        motor_en;
    logic [10:0] thr;
    logic [9:0]  lim;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic signed [19:0] roll_integ;
    logic signed [19:0] pitch_integ;
  } back_stat_t;

endpackage

[src/dpqm_front.sv]
// Front end: accepts sensor items, classifies them against the throttle and
// near-zero window, and forms the gain products. Depends on dpqm_pkg.
`timescale 1ns / 1ps

module dpqm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dpqm_pkg::cfg_t        cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [95:0]           in_tdata,
  input  dpqm_pkg::queue_stat_t q_stat,
  output logic                  push,
  output dpqm_pkg::work_t       push_data
);

  logic signed [12:0] ra, pa, rt, pt;
  logic signed [15:0] rr, pr;
  logic [10:0]        thr;
  logic signed [13:0] re, pe;
  logic               quiet;
  logic [9:0]         half_thr;
  logic signed [30:0] rp_prod, ri_prod, pp_prod, pi_prod;
  logic signed [32:0] rd_prod, pd_prod;
  dpqm_pkg::work_t    work_nxt;
  dpqm_pkg::work_t    work_r;
  logic               valid_r;
  logic               advance;

  assign ra  = in_tdata[12:0];
  assign pa  = in_tdata[25:13];
  assign rt  = in_tdata[38:26];
  assign pt  = in_tdata[51:39];
  assign rr  = in_tdata[67:52];
  assign pr  = in_tdata[83:68];
  assign thr = in_tdata[94:84];

  assign re = 14'(ra) + 14'(rt);
  assign pe = 14'(pa) + 14'(pt);

  assign quiet = (rt >= -dpqm_pkg::TARGET_QUIET_MAX) && (rt <= dpqm_pkg::TARGET_QUIET_MAX) &&
                 (pt >= -dpqm_pkg::TARGET_QUIET_MAX) && (pt <= dpqm_pkg::TARGET_QUIET_MAX) &&
                 (ra >= -dpqm_pkg::ANGLE_QUIET_MAX)  && (ra <= dpqm_pkg::ANGLE_QUIET_MAX)  &&
                 (pa >= -dpqm_pkg::ANGLE_QUIET_MAX)  && (pa <= dpqm_pkg::ANGLE_QUIET_MAX);

  assign half_thr = thr[10:1];

  assign rp_prod = $signed({1'b0, cfg.roll_p}) * re;
  assign ri_prod = $signed({1'b0, cfg.roll_i}) * re;
  assign rd_prod = $signed({1'b0, cfg.roll_d}) * rr;
  assign pp_prod = $signed({1'b0, cfg.pitch_p}) * pe;
  assign pi_prod = $signed({1'b0, cfg.pitch_i}) * pe;
  assign pd_prod = $signed({1'b0, cfg.pitch_d}) * pr;

  always_comb begin
    work_nxt.roll.p_term  = rp_prod;
    work_nxt.roll.i_step  = ri_prod[30:3];   // floor(I*e/8)
    work_nxt.roll.d_term  = rd_prod;
    work_nxt.pitch.p_term = pp_prod;
    work_nxt.pitch.i_step = pi_prod[30:3];
    work_nxt.pitch.d_term = pd_prod;
    work_nxt.motor_en     = thr > cfg.min_thr;
    work_nxt.thr          = thr;
    work_nxt.lim          = (half_thr > cfg.int_cap) ? cfg.int_cap : half_thr;
    priority if (thr < cfg.min_thr) begin
      work_nxt.op = dpqm_pkg::INTEG_CLEAR;
    end else if (quiet && (thr > cfg.min_thr)) begin
      work_nxt.op = dpqm_pkg::INTEG_ACCUM;
    end else begin
      work_nxt.op = dpqm_pkg::INTEG_HOLD;
    end
  end

  // Hold the staged item until the queue has room.
  assign advance   = !valid_r || !q_stat.full;
  assign in_tready = advance;
  assign push      = valid_r && !q_stat.full;
  assign push_data = work_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_tvalid) begin
      work_r <= work_nxt;
    end
  end

endmodule

[src/dpqm_queue.sv]
// Short FIFO of classified items between front and back ends.
// Depends on dpqm_pkg.
`timescale 1ns / 1ps

module dpqm_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dpqm_pkg::work_t       push_data,
  input  logic                  pop,
  output dpqm_pkg::work_t       head,
  output dpqm_pkg::queue_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dpqm_pkg::work_t  entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign head         = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/dpqm_back.sv]
// Back end: integral update, axis sums, X mixing and saturation, with the
// output register. Depends on dpqm_pkg.
`timescale 1ns / 1ps

module dpqm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dpqm_pkg::work_t       head,
  input  dpqm_pkg::queue_stat_t q_stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,
  output dpqm_pkg::back_stat_t  stat
);

  function automatic logic signed [19:0] integ_next(
    input logic signed [19:0] cur,
    input logic signed [27:0] step,
    input logic [9:0]         lim,
    input dpqm_pkg::integ_op_t op
  );
    logic signed [28:0] sum;
    logic signed [28:0] bound;
    logic signed [28:0] nbound;
    logic signed [19:0] res;
    sum    = 29'(cur) + 29'(step);
    bound  = $signed({10'd0, lim, 9'd0});
    nbound = -bound;
    unique case (op)
      dpqm_pkg::INTEG_CLEAR: res = '0;
      dpqm_pkg::INTEG_ACCUM: begin
        if (sum > bound) begin
          res = bound[19:0];
        end else if (sum < nbound) begin
          res = nbound[19:0];
        end else begin
          res = sum[19:0];
        end
      end
      default: res = cur;
    endcase
    return res;
  endfunction

  function automatic logic signed [37:0] axis_sum(
    input dpqm_pkg::axis_terms_t t,
    input logic signed [19:0]    integ
  );
    return 38'(t.p_term) + (38'(integ) <<< 3) + (38'(t.d_term) <<< 4);
  endfunction

  // base +/- a +/- b, divided by 4096 toward zero, saturated to 16 bits.
  function automatic logic [15:0] mix(
    input logic signed [39:0] base,
    input logic signed [37:0] a,
    input logic               a_neg,
    input logic signed [37:0] b,
    input logic               b_neg
  );
    logic signed [39:0] sa, sb, x, adj, q;
    logic [15:0] res;
    sa  = a_neg ? -40'(a) : 40'(a);
    sb  = b_neg ? -40'(b) : 40'(b);
    x   = base + sa + sb;
    adj = x + (x[39] ? 40'sd4095 : 40'sd0);
    q   = adj >>> 12;
    if (q > 40'sd32767) begin
      res = 16'h7FFF;
    end else if (q < -40'sd32768) begin
      res = 16'h8000;
    end else begin
      res = q[15:0];
    end
    return res;
  endfunction

  logic                  adv;
  logic                  s1_valid_r, s2_valid_r, out_valid_r;
  dpqm_pkg::axis_terms_t s1_roll_r, s1_pitch_r;
  logic [10:0]           s1_thr_r, s2_thr_r;
  logic                  s1_en_r, s2_en_r;
  logic signed [19:0]    roll_integ_r, pitch_integ_r;
  logic signed [37:0]    rout_r, pout_r;
  logic signed [39:0]    base;
  logic [63:0]           out_nxt;
  logic [63:0]           out_data_r;

  // The whole back end moves in lock step; stall it when the output holds.
  assign adv = !out_valid_r || out_tready;
  assign pop = adv && !q_stat.empty;

  assign stat.roll_integ  = roll_integ_r;
  assign stat.pitch_integ = pitch_integ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      roll_integ_r  <= '0;
      pitch_integ_r <= '0;
    end else begin
      if (adv) begin
        s1_valid_r  <= pop;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
      if (pop) begin
        roll_integ_r  <= integ_next(roll_integ_r, head.roll.i_step, head.lim, head.op);
        pitch_integ_r <= integ_next(pitch_integ_r, head.pitch.i_step, head.lim, head.op);
      end
    end
  end

  // Stage 2 reads the integrals the stage-1 item left; they only move on pop,
  // which also advances that item.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_roll_r  <= head.roll;
      s1_pitch_r <= head.pitch;
      s1_thr_r   <= head.thr;
      s1_en_r    <= head.motor_en;
      rout_r     <= axis_sum(s1_roll_r, roll_integ_r);
      pout_r     <= axis_sum(s1_pitch_r, pitch_integ_r);
      s2_thr_r   <= s1_thr_r;
      s2_en_r    <= s1_en_r;
      out_data_r <= out_nxt;
    end
  end

  assign base = $signed({17'd0, s2_thr_r, 12'd0});

  always_comb begin
    if (s2_en_r) begin
      out_nxt = {mix(base, rout_r, 1'b1, pout_r, 1'b0),
                 mix(base, rout_r, 1'b0, pout_r, 1'b0),
                 mix(base, rout_r, 1'b0, pout_r, 1'b1),
                 mix(base, rout_r, 1'b1, pout_r, 1'b1)};
    end else begin
      out_nxt = '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[src/dual_axis_pid_quad_mixer_unit.sv]
// Top level of the dual-axis PID quad mixer: configuration registers and the
// front, queue and back instances. Depends on dpqm_pkg and the dpqm_* modules.
`timescale 1ns / 1ps

// Roll/pitch attitude PID with an X-frame mixer. Each input request carries
// the two angles, two targets, two gyro rates and throttle; each output
// request carries four saturated motor values. The block takes one request
// per clock and delivers one per clock when the output side is ready; the
// figure is set by the integral update, one add and clamp per axis that each
// request performs against the integral left by the one before it. From input
// accept to output valid, a request with an empty queue passes through the
// front stage register, a queue slot and the three back stages, in that order.
// Configuration writes are always ready and take effect on the next accepted
// request; write them only while no request is in flight. The integrals reset
// to zero, clear while throttle is below min_throttle and hold while it equals
// min_throttle.
module dual_axis_pid_quad_mixer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // roll_angle[12:0], pitch_angle[25:13], roll_target[38:26],
  // pitch_target[51:39], roll_rate[67:52], pitch_rate[83:68],
  // throttle[94:84], zero pad[95]
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // motor_one[15:0], motor_two[31:16], motor_three[47:32], motor_four[63:48]
  output logic [63:0] out_tdata
);

  dpqm_pkg::cfg_t        cfg_r;
  dpqm_pkg::queue_stat_t q_stat;
  dpqm_pkg::work_t       push_data;
  dpqm_pkg::work_t       head;
  dpqm_pkg::back_stat_t  back_stat;
  logic                  push;
  logic                  pop;

  assign cfg_ready = 1'b1;

  // Register file: truncate each write to the register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.roll_p  <= dpqm_pkg::RST_P_GAIN;
      cfg_r.roll_i  <= dpqm_pkg::RST_I_GAIN;
      cfg_r.roll_d  <= dpqm_pkg::RST_D_GAIN;
      cfg_r.pitch_p <= dpqm_pkg::RST_P_GAIN;
      cfg_r.pitch_i <= dpqm_pkg::RST_I_GAIN;
      cfg_r.pitch_d <= dpqm_pkg::RST_D_GAIN;
      cfg_r.int_cap <= dpqm_pkg::RST_INT_CAP;
      cfg_r.min_thr <= dpqm_pkg::RST_MIN_THR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dpqm_pkg::cfg_reg_t'(cfg_index))
        dpqm_pkg::REG_ROLL_P:  cfg_r.roll_p  <= cfg_data;
        dpqm_pkg::REG_ROLL_I:  cfg_r.roll_i  <= cfg_data;
        dpqm_pkg::REG_ROLL_D:  cfg_r.roll_d  <= cfg_data;
        dpqm_pkg::REG_PITCH_P: cfg_r.pitch_p <= cfg_data;
        dpqm_pkg::REG_PITCH_I: cfg_r.pitch_i <= cfg_data;
        dpqm_pkg::REG_PITCH_D: cfg_r.pitch_d <= cfg_data;
        dpqm_pkg::REG_INT_CAP: cfg_r.int_cap <= cfg_data[9:0];
        dpqm_pkg::REG_MIN_THR: cfg_r.min_thr <= cfg_data[10:0];
      endcase
    end
  end

  // Front: classify and multiply.
  dpqm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: decouple front stalls from back stalls.
  dpqm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Back: integrate, sum, mix, saturate.
  dpqm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (back_stat)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (back_stat.roll_integ <= dpqm_pkg::INTEG_BOUND) &&
    (back_stat.roll_integ >= -dpqm_pkg::INTEG_BOUND) &&
    (back_stat.pitch_integ <= dpqm_pkg::INTEG_BOUND) &&
    (back_stat.pitch_integ >= -dpqm_pkg::INTEG_BOUND))
    else $error("integral beyond clamp bound");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for dual_axis_pid_quad_mixer_unit: attitude requests from a queue,
// an in-bench PID and mixer predictor, and a checker on every motor result.
// Depends on dpqm_pkg and the RTL under src/.
`timescale 1ns / 1ps

module testbench;

  // Run ceiling, several times the slowest legal run.
  localparam longint TIMEOUT_NS = 64'd8_000_000;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int LONG_HOLD_CYCLES = 400;

  // Input request layout, lowest field last so it lands in the low bits.
  typedef struct packed {
    logic               pad;
    logic [10:0]        throttle;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] roll_rate;
    logic signed [12:0] pitch_target;
    logic signed [12:0] roll_target;
    logic signed [12:0] pitch_angle;
    logic signed [12:0] roll_angle;
  } attitude_t;

  typedef struct packed {
    logic signed [15:0] motor_four;
    logic signed [15:0] motor_three;
    logic signed [15:0] motor_two;
    logic signed [15:0] motor_one;
  } motor_set_t;

  typedef struct {
    dpqm_pkg::cfg_reg_t idx;
    logic [15:0]        data;
  } reg_write_t;

  // Kinds of random stimulus.
  typedef enum int {
    GEN_HOVER_RUN,
    GEN_BROKEN_RUN,
    GEN_WILD,
    GEN_THR_EDGE
  } gen_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  attitude_t  in_tdata = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [63:0] out_tdata;

  dual_axis_pid_quad_mixer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // roll_angle, pitch_angle, roll_target, pitch_target, roll_rate,
    // pitch_rate, throttle, zero pad
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // motor_one, motor_two, motor_three, motor_four
    .out_tdata  (out_tdata)
  );

  // Pending stimulus and the expected motor results in flight.
  attitude_t  attitude_q[$];
  reg_write_t reg_write_q[$];
  motor_set_t motor_expect_q[$];

  // Predictor state: a shadow of the registers and both integrals.
  dpqm_pkg::cfg_t     live_cfg;
  logic signed [19:0] roll_integ;
  logic signed [19:0] pitch_integ;

  // Idle shaping, written by the sequencer only at falling edges.
  int in_gap_max = 0;
  int out_gap_max = 0;
  int hold_at_result = -1;
  int plan_min_thr = dpqm_pkg::RST_MIN_THR;

  int failures = 0;
  int results_seen = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic signed [19:0] step_integral(logic signed [19:0] cur, longint gain,
                                                       longint err, longint lim);
    longint acc;
    // floor(gain*err/8) is an arithmetic shift on a signed product
    acc = longint'(cur) + ((gain * err) >>> 3);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    return 20'(acc);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Advance the integrals for one request and return the four motor values.
  function automatic motor_set_t predict_motors(attitude_t a);
    longint ra, pa, rt, pt, rr, pr, thr, min_thr, lim, re, pe, rout, pout, base;
    bit quiet;
    motor_set_t m;
    ra = $signed(a.roll_angle);
    pa = $signed(a.pitch_angle);
    rt = $signed(a.roll_target);
    pt = $signed(a.pitch_target);
    rr = $signed(a.roll_rate);
    pr = $signed(a.pitch_rate);
    thr = longint'(a.throttle);
    min_thr = longint'(live_cfg.min_thr);
    re = ra + rt;
    pe = pa + pt;

    // Integral limit: half the throttle, capped, in 1/512 output units.
    lim = thr / 2;
    if (lim > longint'(live_cfg.int_cap)) lim = longint'(live_cfg.int_cap);
    lim = lim * 512;

    // Near-zero window: both targets under 0.1 sq deg, both angles under 30 sq deg.
    quiet = (rt * rt * 10 < 256) && (pt * pt * 10 < 256) &&
            (ra * ra < 30 * 256) && (pa * pa < 30 * 256);

    if (quiet && thr > min_thr) begin
      roll_integ  = step_integral(roll_integ, longint'(live_cfg.roll_i), re, lim);
      pitch_integ = step_integral(pitch_integ, longint'(live_cfg.pitch_i), pe, lim);
    end else if (thr < min_thr) begin
      roll_integ  = '0;
      pitch_integ = '0;
    end

    // Axis outputs in Q.12 output units.
    rout = longint'(live_cfg.roll_p) * re + longint'(roll_integ) * 8 +
           longint'(live_cfg.roll_d) * rr * 16;
    pout = longint'(live_cfg.pitch_p) * pe + longint'(pitch_integ) * 8 +
           longint'(live_cfg.pitch_d) * pr * 16;

    m = '0;
    if (thr > min_thr) begin
      base = thr * 4096;
      // integer division truncates toward zero
      m.motor_one   = clip16((base - rout - pout) / 4096);
      m.motor_two   = clip16((base + rout - pout) / 4096);
      m.motor_three = clip16((base + rout + pout) / 4096);
      m.motor_four  = clip16((base - rout + pout) / 4096);
    end
    return m;
  endfunction

  function automatic void apply_register(dpqm_pkg::cfg_reg_t idx, logic [15:0] d);
    case (idx)
      dpqm_pkg::REG_ROLL_P:  live_cfg.roll_p  = d;
      dpqm_pkg::REG_ROLL_I:  live_cfg.roll_i  = d;
      dpqm_pkg::REG_ROLL_D:  live_cfg.roll_d  = d;
      dpqm_pkg::REG_PITCH_P: live_cfg.pitch_p = d;
      dpqm_pkg::REG_PITCH_I: live_cfg.pitch_i = d;
      dpqm_pkg::REG_PITCH_D: live_cfg.pitch_d = d;
      dpqm_pkg::REG_INT_CAP: live_cfg.int_cap = d[9:0];
      dpqm_pkg::REG_MIN_THR: live_cfg.min_thr = d[10:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: register writes first, then attitude requests with random gaps
  // ---------------------------------------------------------------------

  int         gap_left;
  reg_write_t next_write;

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid   <= 1'b0;
      in_tvalid   <= 1'b0;
      gap_left    = 0;
      live_cfg    = '{roll_p: dpqm_pkg::RST_P_GAIN, roll_i: dpqm_pkg::RST_I_GAIN,
                      roll_d: dpqm_pkg::RST_D_GAIN, pitch_p: dpqm_pkg::RST_P_GAIN,
                      pitch_i: dpqm_pkg::RST_I_GAIN, pitch_d: dpqm_pkg::RST_D_GAIN,
                      int_cap: dpqm_pkg::RST_INT_CAP, min_thr: dpqm_pkg::RST_MIN_THR};
      roll_integ  = '0;
      pitch_integ = '0;
    end else begin
      // Record what this edge accepted before deciding the next cycle.
      if (cfg_valid && cfg_ready)
        apply_register(dpqm_pkg::cfg_reg_t'(cfg_index), cfg_data);
      if (in_tvalid && in_tready)
        motor_expect_q.push_back(predict_motors(in_tdata));

      if (!cfg_valid || cfg_ready) begin
        if (reg_write_q.size() > 0) begin
          next_write = reg_write_q.pop_front();
          cfg_valid  <= 1'b1;
          cfg_index  <= next_write.idx;
          cfg_data   <= next_write.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end

      // Hold requests back until every queued register write has landed.
      if (!in_tvalid || in_tready) begin
        if (reg_write_q.size() > 0 || cfg_valid) begin
          in_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (attitude_q.size() > 0) begin
          in_tdata  <= attitude_q.pop_front();
          in_tvalid <= 1'b1;
          gap_left  = $urandom_range(0, in_gap_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each motor result with the oldest expectation
  // ---------------------------------------------------------------------

  function automatic void check_motor(string name, logic signed [15:0] want,
                                      logic signed [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  int         rx_wait;
  int         hold_left;
  motor_set_t got_motors;
  motor_set_t want_motors;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    = 0;
      hold_left  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_motors = out_tdata;
        if (motor_expect_q.size() == 0) begin
          $error("motor result with none expected: %h", out_tdata);
          failures++;
        end else begin
          want_motors = motor_expect_q.pop_front();
          check_motor("motor_one", want_motors.motor_one, got_motors.motor_one);
          check_motor("motor_two", want_motors.motor_two, got_motors.motor_two);
          check_motor("motor_three", want_motors.motor_three, got_motors.motor_three);
          check_motor("motor_four", want_motors.motor_four, got_motors.motor_four);
        end
        results_seen++;
        // Long hold-off so the sender backs up against a full block.
        if (results_seen == hold_at_result)
          hold_left = LONG_HOLD_CYCLES;
        rx_wait = $urandom_range(0, out_gap_max);
      end

      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic attitude_t make_att(int ra, int pa, int rt, int pt, int rr, int pr,
                                         int thr);
    attitude_t a;
    a = '0;
    a.roll_angle   = 13'(ra);
    a.pitch_angle  = 13'(pa);
    a.roll_target  = 13'(rt);
    a.pitch_target = 13'(pt);
    a.roll_rate    = 16'(rr);
    a.pitch_rate   = 16'(pr);
    a.throttle     = 11'(thr);
    return a;
  endfunction

  function automatic logic [10:0] thr_above(int m);
    if (m >= 2047) return 11'd2047;
    return 11'($urandom_range(m + 1, 2047));
  endfunction

  // Hover request: targets and angles straddle the near-zero window, throttle armed.
  function automatic attitude_t hover_att(int m);
    attitude_t a;
    a = '0;
    a.roll_target  = 13'($urandom_range(0, 12) - 6);
    a.pitch_target = 13'($urandom_range(0, 12) - 6);
    a.roll_angle   = 13'($urandom_range(0, 180) - 90);
    a.pitch_angle  = 13'($urandom_range(0, 180) - 90);
    if ($urandom_range(0, 3) == 0) begin
      a.roll_rate  = 16'($urandom());
      a.pitch_rate = 16'($urandom());
    end else begin
      a.roll_rate  = 16'($urandom_range(0, 8190) - 4095);
      a.pitch_rate = 16'($urandom_range(0, 8190) - 4095);
    end
    a.throttle = thr_above(m);
    return a;
  endfunction

  function automatic attitude_t wild_att();
    attitude_t a;
    a = '0;
    a.roll_angle   = 13'($urandom());
    a.pitch_angle  = 13'($urandom());
    a.roll_target  = 13'($urandom());
    a.pitch_target = 13'($urandom());
    a.roll_rate    = 16'($urandom());
    a.pitch_rate   = 16'($urandom());
    a.throttle     = 11'($urandom());
    return a;
  endfunction

  // Throttle just below, at and above the arming level, plus both ends.
  function automatic attitude_t thr_edge_att(int m);
    attitude_t a;
    a = hover_att(m);
    case ($urandom_range(0, 4))
      0: a.throttle = (m > 0) ? 11'(m - 1) : 11'd0;
      1: a.throttle = 11'(m);
      2: a.throttle = (m < 2047) ? 11'(m + 1) : 11'd2047;
      3: a.throttle = 11'd0;
      default: a.throttle = 11'd2047;
    endcase
    return a;
  endfunction

  // Knock one field of a hover request just outside the near-zero window.
  function automatic attitude_t break_window(attitude_t a);
    attitude_t b;
    b = a;
    case ($urandom_range(0, 3))
      0: b.roll_target  = 13'($urandom_range(6, 60));
      1: b.pitch_target = -13'($urandom_range(6, 60));
      2: b.roll_angle   = -13'($urandom_range(88, 400));
      default: b.pitch_angle = 13'($urandom_range(88, 400));
    endcase
    return b;
  endfunction

  task automatic queue_config(int rp, int ri, int rd, int pp, int pi, int pd, int cap,
                              int min_thr);
    reg_write_q.push_back('{dpqm_pkg::REG_ROLL_P, 16'(rp)});
    reg_write_q.push_back('{dpqm_pkg::REG_ROLL_I, 16'(ri)});
    reg_write_q.push_back('{dpqm_pkg::REG_ROLL_D, 16'(rd)});
    reg_write_q.push_back('{dpqm_pkg::REG_PITCH_P, 16'(pp)});
    reg_write_q.push_back('{dpqm_pkg::REG_PITCH_I, 16'(pi)});
    reg_write_q.push_back('{dpqm_pkg::REG_PITCH_D, 16'(pd)});
    reg_write_q.push_back('{dpqm_pkg::REG_INT_CAP, 16'(cap)});
    reg_write_q.push_back('{dpqm_pkg::REG_MIN_THR, 16'(min_thr)});
    plan_min_thr = min_thr;
  endtask

  function automatic int rand_gain();
    return $urandom_range(0, 65535) >> $urandom_range(0, 15);
  endfunction

  task automatic queue_random_config();
    int min_thr;
    min_thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 200);
    queue_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                 $urandom_range(0, 1023), min_thr);
  endtask

  // Mostly hover runs with random content; the rest noise, broken runs and throttle edges.
  task automatic queue_random_items(int n);
    int left;
    int len;
    int brk;
    gen_kind_t kind;
    int pick;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      kind = (pick <= 5) ? GEN_HOVER_RUN : (pick == 6) ? GEN_BROKEN_RUN :
             (pick == 7) ? GEN_WILD : GEN_THR_EDGE;
      case (kind)
        GEN_HOVER_RUN, GEN_BROKEN_RUN: begin
          len = $urandom_range(4, 20);
          brk = $urandom_range(0, len - 1);
          for (int j = 0; j < len && left > 0; j++) begin
            if (kind == GEN_BROKEN_RUN && j == brk)
              attitude_q.push_back(break_window(hover_att(plan_min_thr)));
            else
              attitude_q.push_back(hover_att(plan_min_thr));
            left--;
          end
        end
        GEN_WILD: begin
          attitude_q.push_back(wild_att());
          left--;
        end
        default: begin
          attitude_q.push_back(thr_edge_att(plan_min_thr));
          left--;
        end
      endcase
    end
  endtask

  // Wait at falling edges until nothing is queued, offered or outstanding.
  task automatic drain();
    @(negedge clk);
    while (attitude_q.size() > 0 || reg_write_q.size() > 0 || in_tvalid || cfg_valid ||
           motor_expect_q.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    // Hold reset, then release it at a rising edge.
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests at the reset register values (arming level 40).
    in_gap_max  = 2;
    out_gap_max = 2;
    attitude_q.push_back(make_att(0, 0, 0, 0, 0, 0, 0));
    attitude_q.push_back(make_att(-4096, -4096, -4096, -4096, -32768, -32768, 2047));
    attitude_q.push_back(make_att(4095, 4095, 4095, 4095, 32767, 32767, 2047));
    attitude_q.push_back(make_att(4095, -4096, -4096, 4095, 32767, -32768, 2047));
    attitude_q.push_back(make_att(-4096, 4095, 4095, -4096, -32768, 32767, 1));
    // Accumulate inside the window, right at its edges.
    attitude_q.push_back(make_att(87, -87, 5, -5, 0, 0, 41));
    attitude_q.push_back(make_att(87, -87, 5, -5, 0, 0, 41));
    attitude_q.push_back(make_att(87, 87, 5, 5, 100, -100, 2047));
    attitude_q.push_back(make_att(87, 87, 5, 5, 100, -100, 2047));
    attitude_q.push_back(make_att(-87, -87, -5, -5, -100, 100, 2047));
    // Just outside the window on each field: integrals hold.
    attitude_q.push_back(make_att(88, 0, 0, 0, 0, 0, 500));
    attitude_q.push_back(make_att(0, -88, 0, 0, 0, 0, 500));
    attitude_q.push_back(make_att(0, 0, 6, 0, 0, 0, 500));
    attitude_q.push_back(make_att(0, 0, 0, -6, 0, 0, 500));
    // Throttle at the arming level holds, below it clears.
    attitude_q.push_back(make_att(10, 10, 0, 0, 0, 0, 40));
    attitude_q.push_back(make_att(10, 10, 0, 0, 0, 0, 41));
    attitude_q.push_back(make_att(10, 10, 0, 0, 0, 0, 39));
    attitude_q.push_back(make_att(-87, -87, -5, -5, 0, 0, 41));
    attitude_q.push_back(make_att(-87, -87, -5, -5, 0, 0, 3));
    attitude_q.push_back(make_att(0, 0, 0, 0, 0, 0, 42));
    drain();

    // Largest gains, largest cap, arming level zero: heavy saturation.
    in_gap_max  = 19;
    out_gap_max = 19;
    queue_config(65535, 65535, 65535, 65535, 65535, 65535, 1023, 0);
    queue_random_items(120);
    drain();

    // All gains and cap zero, arming level at full scale: motors stay off.
    in_gap_max  = 0;
    out_gap_max = 0;
    queue_config(0, 0, 0, 0, 0, 0, 0, 2047);
    queue_random_items(40);
    drain();

    // Zero cap with live gains: accumulation must leave the integrals at zero.
    in_gap_max  = 5;
    out_gap_max = 5;
    queue_config(rand_gain(), 65535, rand_gain(), rand_gain(), 40000, rand_gain(), 0, 20);
    queue_random_items(60);
    drain();

    // Random settings with a rotating mix of sender and receiver idling.
    for (int p = 0; p < 7; p++) begin
      in_gap_max  = (p % 4 == 1 || p % 4 == 2) ? 19 : 0;
      out_gap_max = (p % 4 == 1 || p % 4 == 3) ? 19 : 0;
      // One phase stalls the receiver hard while the sender streams.
      if (p == 4) begin
        in_gap_max     = 0;
        hold_at_result = results_seen + 25;
      end
      queue_random_config();
      queue_random_items(160);
      drain();
    end

    // Let any stray result surface before judging.
    repeat (20) @(negedge clk);
    if (failures == 0 && motor_expect_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
src/dpqm_pkg.sv
src/dpqm_front.sv
src/dpqm_queue.sv
src/dpqm_back.sv
src/dual_axis_pid_quad_mixer_unit.sv
dv/testbench.sv
